[sv/pollard_rho_factor_top_macros.svh]
// Assertion macros for the Pollard rho factor block
`ifndef POLLARD_RHO_FACTOR_TOP_MACROS_SVH
`define POLLARD_RHO_FACTOR_TOP_MACROS_SVH
// implication checked every clock outside reset
`define PRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define PRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

[sv/prf_pkg.sv]
// Package for the Pollard rho factor block
package prf_pkg;
  localparam int unsigned WIDTH_DEF = 32;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;
endpackage

[sv/prf_modmul.sv]
// Bit-serial modular multiply-add: (a*b + c) mod n, one multiplier bit per cycle
module prf_modmul #(
  parameter int unsigned WIDTH = prf_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] c,
  input  logic [WIDTH-1:0] n,
  output logic             done,
  output logic [WIDTH-1:0] res
);
  localparam int unsigned CW = $clog2(WIDTH + 2);

  logic [WIDTH-1:0] acc_r, acc_nxt, a_r, b_r, c_r, n_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [WIDTH:0]   dbl, dsub, add, asub;
  logic [WIDTH-1:0] dred;

  always_comb begin
    dbl  = {acc_r, 1'b0};
    dsub = dbl - {1'b0, n_r};
    dred = dsub[WIDTH] ? dbl[WIDTH-1:0] : dsub[WIDTH-1:0];
    add  = {1'b0, dred} + (b_r[WIDTH-1] ? {1'b0, a_r} : '0);
    asub = add - {1'b0, n_r};
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      cnt_nxt  = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        add  = {1'b0, acc_r} + {1'b0, c_r};
        asub = add - {1'b0, n_r};
        acc_nxt  = asub[WIDTH] ? add[WIDTH-1:0] : asub[WIDTH-1:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        acc_nxt = asub[WIDTH] ? add[WIDTH-1:0] : asub[WIDTH-1:0];
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    if (start) begin
      a_r <= a;
      b_r <= b;
      c_r <= c;
      n_r <= n;
    end else if (busy_r && cnt_r != '0) begin
      b_r <= {b_r[WIDTH-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign res  = acc_r;
endmodule

[sv/pollard_rho_factor_top.sv]
// Top level of the Pollard rho factor block
// Usage:
//   Input channel in_valid/in_stall carries modulus, increment, start_value.
//   Result channel out_valid/out_stall carries factor and status.
//   One item is processed at a time; in_stall is high while busy or while
//   a result waits.
//   Setup reduces x0 and c mod n with a bit-serial shift-subtract. Every round
//   runs three map steps through one bit-serial modular multiplier, then a
//   binary gcd that takes one shift or subtract step a cycle, plus the GINIT,
//   GFIN and CHK states for setup and check. The round count grows with the
//   square root of the smallest factor of n. A modulus below two gives
//   status 1 and factor 0 on the cycle after the item is taken.
//   Reset clears the controller; no item is in flight afterwards.
//   When out_stall is high the result holds on the ports until taken.
module pollard_rho_factor_top #(
  parameter int unsigned WIDTH = prf_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_modulus,
  input  logic [WIDTH-1:0] in_increment,
  input  logic [WIDTH-1:0] in_start_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_factor,
  output logic             out_status
);
  import prf_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH + 2);
  localparam int unsigned SW = $clog2(WIDTH + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RED   = 10'b0000000010,
    S_MS    = 10'b0000000100,
    S_MF1   = 10'b0000001000,
    S_MF2   = 10'b0000010000,
    S_GINIT = 10'b0000100000,
    S_GCD   = 10'b0001000000,
    S_GFIN  = 10'b0010000000,
    S_CHK   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t           st_r, st_nxt;
  logic [WIDTH-1:0] n_r, c_r, slow_r, fast_r, fact_r;
  logic             stat_r, sel_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] quo_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] ga_r, gb_r;
  logic [SW-1:0]    sh_r;
  logic             acc;

  logic             mm_start, mm_done;
  logic [WIDTH-1:0] mm_a, mm_res;
  logic [WIDTH:0]   rsh, rsub;

  assign acc = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_factor = fact_r;
  assign out_status = stat_r;

  always_comb begin
    rsh  = {rem_r, quo_r[WIDTH-1]};
    rsub = rsh - {1'b0, n_r};
  end

  always_comb begin
    mm_a = slow_r;
    if (st_r == S_MF1 || st_r == S_MF2) mm_a = fast_r;
  end

  prf_modmul #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mm_start),
    .a(mm_a), .b(mm_a), .c(c_r), .n(n_r), .done(mm_done), .res(mm_res)
  );

  logic mm_kick_r;
  assign mm_start = mm_kick_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (acc) st_nxt = (in_modulus < WIDTH'(2)) ? S_OUT : S_RED;
      S_RED:   if (cnt_r == '0 && sel_r) st_nxt = S_MS;
      S_MS:    if (mm_done) st_nxt = S_MF1;
      S_MF1:   if (mm_done) st_nxt = S_MF2;
      S_MF2:   if (mm_done) st_nxt = S_GINIT;
      S_GINIT: st_nxt = S_GCD;
      S_GCD:   if (gb_r == '0) st_nxt = S_GFIN;
      S_GFIN:  st_nxt = S_CHK;
      S_CHK:   st_nxt = (ga_r > WIDTH'(1)) ? S_OUT : S_MS;
      S_OUT:   if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      mm_kick_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      mm_kick_r <= (st_r == S_RED && cnt_r == '0 && sel_r) ||
                   (st_r == S_MS && mm_done) || (st_r == S_MF1 && mm_done) ||
                   (st_r == S_CHK && !(ga_r > WIDTH'(1)));
    end
    case (st_r)
      S_IDLE: if (acc) begin
        n_r    <= in_modulus;
        c_r    <= in_increment;
        quo_r  <= in_start_value;
        rem_r  <= '0;
        cnt_r  <= CW'(WIDTH);
        sel_r  <= 1'b0;
        fact_r <= '0;
        stat_r <= (in_modulus < WIDTH'(2)) ? STATUS_BAD : STATUS_OK;
      end
      S_RED: begin
        if (cnt_r == '0) begin
          if (!sel_r) begin
            slow_r <= rem_r;
            fast_r <= rem_r;
            quo_r  <= c_r;
            rem_r  <= '0;
            cnt_r  <= CW'(WIDTH);
            sel_r  <= 1'b1;
          end else begin
            c_r <= rem_r;
          end
        end else begin
          rem_r <= rsub[WIDTH] ? rsh[WIDTH-1:0] : rsub[WIDTH-1:0];
          quo_r <= {quo_r[WIDTH-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
        end
      end
      S_MS:  if (mm_done) slow_r <= mm_res;
      S_MF1: if (mm_done) fast_r <= mm_res;
      S_MF2: if (mm_done) fast_r <= mm_res;
      S_GINIT: begin
        ga_r <= n_r;
        gb_r <= (fast_r >= slow_r) ? fast_r - slow_r : slow_r - fast_r;
        sh_r <= '0;
      end
      S_GCD: if (gb_r != '0) begin
        if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          sh_r <= sh_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (ga_r > gb_r) begin
          ga_r <= gb_r;
          gb_r <= (ga_r - gb_r) >> 1;
        end else begin
          gb_r <= (gb_r - ga_r) >> 1;
        end
      end
      S_GFIN: ga_r <= ga_r << sh_r;
      S_CHK: if (ga_r > WIDTH'(1)) fact_r <= ga_r;
      default: ;
    endcase
  end
endmodule

[sv/prf_checker.sv]
// Port-level checker for the Pollard rho factor block
`include "pollard_rho_factor_top_macros.svh"
module prf_checker #(
  parameter int unsigned WIDTH = prf_pkg::WIDTH_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WIDTH-1:0] out_factor,
  input logic             out_status
);
  import prf_pkg::*;
  `PRF_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_factor) && $stable(out_status))
  `PRF_ASSERT_IMP(a_busy, clk, rst_n, out_valid, in_stall)
  `PRF_ASSERT_NXT(a_take, clk, rst_n, in_valid && !in_stall, in_stall)
  `PRF_ASSERT_IMP(a_err, clk, rst_n, out_valid && out_status == STATUS_BAD, out_factor == '0)
  `PRF_ASSERT_IMP(a_ok, clk, rst_n, out_valid && out_status == STATUS_OK,
    out_factor > WIDTH'(1))
endmodule

bind pollard_rho_factor_top prf_checker #(.WIDTH(WIDTH)) u_prf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_factor(out_factor),
  .out_status(out_status)
);
